// ===== hw/rtl/sds_pkg.sv =====
package sds_pkg;

  // Request store geometry.
  localparam int MAX_REQUESTS = 32;
  localparam int IDX_W        = $clog2(MAX_REQUESTS);
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);

  // Field widths.
  localparam int TRACK_W = 12;
  localparam int SIZE_W  = 13;
  localparam int MOVE_W  = 14;

  // Saturation limit of the movement total.
  localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_DISK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd2;

  // Reset values of the registers.
  localparam logic [SIZE_W-1:0]  DISK_SIZE_RST  = 13'd200;
  localparam logic [TRACK_W-1:0] HEAD_START_RST = 12'd0;
  localparam logic               DIRECTION_RST  = 1'b1;

  // Largest disk size that still maps to its own top track.
  localparam logic [SIZE_W-1:0]  DISK_SIZE_MAX  = 13'd4096;

  // Configuration as seen by the scheduler.
  typedef struct packed {
    logic [TRACK_W-1:0] top_track;
    logic [TRACK_W-1:0] head_start;
    logic               direction;
  } sds_cfg_t;

endpackage

// ===== hw/rtl/sds_if.sv =====
// Request channel: one queued track per item.
interface sds_req_if;
  import sds_pkg::*;

  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] track;
  logic               last;

  modport source (output valid, output track, output last, input ready);
  modport sink   (input valid, input track, input last, output ready);
endinterface

// Result channel: one visited track per item.
interface sds_res_if;
  import sds_pkg::*;

  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] serviced_track;
  logic [MOVE_W-1:0]  total_movement;
  logic               final_res;

  modport source (output valid, output serviced_track, output total_movement,
                  output final_res, input ready);
  modport sink   (input valid, input serviced_track, input total_movement,
                  input final_res, output ready);
endinterface

// ===== hw/rtl/sds_cfg.sv =====
module sds_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [sds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output sds_pkg::sds_cfg_t                cfg
);
  import sds_pkg::*;

  logic [SIZE_W-1:0]  disk_size;
  logic [TRACK_W-1:0] head_start;
  logic               direction;
  logic [SIZE_W-1:0]  size_m1;

  // Register writes; an index outside the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_size  <= DISK_SIZE_RST;
      head_start <= HEAD_START_RST;
      direction  <= DIRECTION_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DISK_SIZE:  disk_size  <= cfg_wdata;
        REG_HEAD_START: head_start <= cfg_wdata[TRACK_W-1:0];
        REG_DIRECTION:  direction  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Top track is size minus one, clamped to the track range.
  assign size_m1 = disk_size - SIZE_W'(1);

  always_comb begin
    cfg.head_start = head_start;
    cfg.direction  = direction;
    if (disk_size == '0) begin
      cfg.top_track = '0;
    end else if (disk_size > DISK_SIZE_MAX) begin
      cfg.top_track = {TRACK_W{1'b1}};
    end else begin
      cfg.top_track = size_m1[TRACK_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/scan_disk_scheduler_core.sv =====
// SCAN disk scheduler. Requests load one per cycle while the core is in its load state
// into a 32-entry store; an item with last set ends the batch (items past 32 are
// dropped, but their last flag still counts). The store then holds the batch while it
// is insertion-sorted in place through its single read and single write port; nearly
// sorted input sorts faster. A scan of the sorted entries for the first track above
// the head follows. Then n+1 results come out for n requests; each but the end-track
// visit reads the store once. No request is taken from the end of the last item until
// the final result is loaded into the output register. The user must hold the
// configuration through the batch; the core itself does not enforce it.
module scan_disk_scheduler_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [sds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  sds_req_if.sink                          req,
  sds_res_if.source                        res
);
  import sds_pkg::*;

  typedef enum logic [8:0] {
    S_LOAD     = 9'b000000001,
    S_SORT_RD  = 9'b000000010,
    S_SORT_V   = 9'b000000100,
    S_SORT_CMP = 9'b000001000,
    S_SORT_PUT = 9'b000010000,
    S_SCAN_RD  = 9'b000100000,
    S_SCAN_CHK = 9'b001000000,
    S_EMIT_RD  = 9'b010000000,
    S_EMIT_OUT = 9'b100000000
  } state_t;

  sds_cfg_t cfg;

  sds_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Request store.
  logic [TRACK_W-1:0] mem [MAX_REQUESTS];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [TRACK_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [TRACK_W-1:0] mem_rdata;

  // Control and working registers.
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   i_idx, i_idx_next;
  logic [IDX_W-1:0]   j_idx, j_idx_next;
  logic [TRACK_W-1:0] v_val, v_val_next;
  logic [IDX_W-1:0]   scan_idx, scan_idx_next;
  logic [CNT_W-1:0]   split, split_next;
  logic [CNT_W-1:0]   k, k_next;
  logic [TRACK_W-1:0] head, head_next;
  logic [MOVE_W-1:0]  move, move_next;
  logic               is_end, is_end_next;

  // Output register.
  logic               out_valid, out_valid_next;
  logic [TRACK_W-1:0] out_track, out_track_next;
  logic [MOVE_W-1:0]  out_move, out_move_next;
  logic               out_final, out_final_next;

  // Helpers.
  logic               req_fire;
  logic               out_free;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   i_inc;
  logic [CNT_W-1:0]   ns;
  logic [CNT_W-1:0]   step_addr;
  logic               step_end;
  logic [TRACK_W-1:0] end_trk;
  logic [TRACK_W-1:0] vis_trk;
  logic [TRACK_W-1:0] vis_diff;
  logic [MOVE_W:0]    vis_sum;
  logic [MOVE_W-1:0]  vis_move;

  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || res.ready;
  assign req.ready = (state == S_LOAD);

  assign res.valid          = out_valid;
  assign res.serviced_track = out_track;
  assign res.total_movement = out_move;
  assign res.final_res      = out_final;

  // Batch size once the current request is counted; a full store drops it.
  assign n_eff = (count < CNT_W'(MAX_REQUESTS)) ? count + CNT_W'(1) : count;
  assign i_inc = {1'b0, i_idx} + CNT_W'(1);

  // Store position of result k in SCAN order.
  assign ns = count - split;
  always_comb begin
    step_end  = 1'b0;
    step_addr = '0;
    if (cfg.direction) begin
      if (k < ns) begin
        step_addr = split + k;
      end else if (k == ns) begin
        step_end = 1'b1;
      end else begin
        step_addr = count - k;
      end
    end else begin
      if (k < split) begin
        step_addr = split - CNT_W'(1) - k;
      end else if (k == split) begin
        step_end = 1'b1;
      end else begin
        step_addr = k - CNT_W'(1);
      end
    end
  end

  // Head movement for the visit being emitted, saturating.
  assign end_trk  = cfg.direction ? cfg.top_track : '0;
  assign vis_trk  = is_end ? end_trk : mem_rdata;
  assign vis_diff = (vis_trk > head) ? vis_trk - head : head - vis_trk;
  assign vis_sum  = {1'b0, move} + (MOVE_W+1)'(vis_diff);
  assign vis_move = (vis_sum > (MOVE_W+1)'(MOVE_MAX)) ? MOVE_MAX : vis_sum[MOVE_W-1:0];

  // Sequencer: load, sort, split search, emission.
  always_comb begin
    state_next     = state;
    count_next     = count;
    i_idx_next     = i_idx;
    j_idx_next     = j_idx;
    v_val_next     = v_val;
    scan_idx_next  = scan_idx;
    split_next     = split;
    k_next         = k;
    head_next      = head;
    move_next      = move;
    is_end_next    = is_end;
    out_valid_next = out_valid && !res.ready;
    out_track_next = out_track;
    out_move_next  = out_move;
    out_final_next = out_final;
    mem_we         = 1'b0;
    mem_waddr      = i_idx;
    mem_wdata      = req.track;
    mem_re         = 1'b0;
    mem_raddr      = i_idx;

    case (state)
      S_LOAD: begin
        if (req_fire) begin
          if (count < CNT_W'(MAX_REQUESTS)) begin
            mem_we    = 1'b1;
            mem_waddr = count[IDX_W-1:0];
            mem_wdata = req.track;
          end
          count_next = n_eff;
          if (req.last) begin
            if (n_eff == CNT_W'(1)) begin
              scan_idx_next = '0;
              state_next    = S_SCAN_RD;
            end else begin
              i_idx_next = IDX_W'(1);
              state_next = S_SORT_RD;
            end
          end
        end
      end

      S_SORT_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = i_idx;
        state_next = S_SORT_V;
      end

      // The new value is in hand; fetch its left neighbor.
      S_SORT_V: begin
        v_val_next = mem_rdata;
        j_idx_next = i_idx;
        mem_re     = 1'b1;
        mem_raddr  = i_idx - IDX_W'(1);
        state_next = S_SORT_CMP;
      end

      // Shift the larger neighbor right, or drop the value into its slot.
      S_SORT_CMP: begin
        if (mem_rdata > v_val) begin
          mem_we     = 1'b1;
          mem_waddr  = j_idx;
          mem_wdata  = mem_rdata;
          j_idx_next = j_idx - IDX_W'(1);
          if (j_idx >= IDX_W'(2)) begin
            mem_re    = 1'b1;
            mem_raddr = j_idx - IDX_W'(2);
          end else begin
            state_next = S_SORT_PUT;
          end
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = j_idx;
          mem_wdata  = v_val;
          i_idx_next = i_inc[IDX_W-1:0];
          if (i_inc == count) begin
            scan_idx_next = '0;
            state_next    = S_SCAN_RD;
          end else begin
            state_next = S_SORT_RD;
          end
        end
      end

      S_SORT_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = j_idx;
        mem_wdata  = v_val;
        i_idx_next = i_inc[IDX_W-1:0];
        if (i_inc == count) begin
          scan_idx_next = '0;
          state_next    = S_SCAN_RD;
        end else begin
          state_next = S_SORT_RD;
        end
      end

      S_SCAN_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = scan_idx;
        state_next = S_SCAN_CHK;
      end

      // The split is the first sorted request strictly above the head.
      S_SCAN_CHK: begin
        if (mem_rdata > cfg.head_start) begin
          split_next = {1'b0, scan_idx};
          k_next     = '0;
          head_next  = cfg.head_start;
          move_next  = '0;
          state_next = S_EMIT_RD;
        end else if (({1'b0, scan_idx} + CNT_W'(1)) == count) begin
          split_next = count;
          k_next     = '0;
          head_next  = cfg.head_start;
          move_next  = '0;
          state_next = S_EMIT_RD;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
          state_next    = S_SCAN_RD;
        end
      end

      S_EMIT_RD: begin
        is_end_next = step_end;
        mem_re      = !step_end;
        mem_raddr   = step_addr[IDX_W-1:0];
        state_next  = S_EMIT_OUT;
      end

      // Load one visit into the output register once it is free.
      S_EMIT_OUT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_track_next = vis_trk;
          out_final_next = (k == count);
          out_move_next  = (k == count) ? vis_move : '0;
          head_next      = vis_trk;
          move_next      = vis_move;
          k_next         = k + CNT_W'(1);
          if (k == count) begin
            count_next = '0;
            state_next = S_LOAD;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end

      default: state_next = S_LOAD;
    endcase
  end

  // Store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    i_idx     <= i_idx_next;
    j_idx     <= j_idx_next;
    v_val     <= v_val_next;
    scan_idx  <= scan_idx_next;
    split     <= split_next;
    k         <= k_next;
    head      <= head_next;
    move      <= move_next;
    is_end    <= is_end_next;
    out_track <= out_track_next;
    out_move  <= out_move_next;
    out_final <= out_final_next;
  end

  // A new result appears only from the emission step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT_OUT))
    else $error("result loaded outside emission");

  // Only the final result carries a movement total.
  a_move_on_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_final |-> out_move == '0)
    else $error("movement on a non-final result");

  // The batch never outgrows the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_REQUESTS))
    else $error("request count beyond store depth");

  // Sort writes stay inside the batch.
  a_sort_write: assert property (@(posedge clk) disable iff (rst)
    mem_we && state != S_LOAD |-> {1'b0, mem_waddr} < count)
    else $error("sort write outside batch");

  // Emission never runs past the final result.
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD || state == S_EMIT_OUT) |-> k <= count)
    else $error("emission index past batch end");

endmodule

// ===== dv/scan_order_checker.sv =====
`timescale 1ns / 100ps

// Watches the request and result channels of the SCAN scheduler, predicts the
// service order of every batch and compares each result item against it.
module scan_order_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sds_pkg::CFG_DATA_W-1:0] cfg_wdata,
  sds_req_if                             req,
  sds_res_if                             res,
  output int                             mismatches,
  output int                             visits_due,
  output int                             visits_checked
);
  import sds_pkg::*;

  typedef struct packed {
    logic [TRACK_W-1:0] trk;
    logic [MOVE_W-1:0]  moved;
    logic               fin;
  } visit_t;

  // Shadow copy of the configuration registers.
  logic [SIZE_W-1:0]  size_q;
  logic [TRACK_W-1:0] head_q;
  logic               dir_q;

  // Shadow copy of the request store.
  logic [TRACK_W-1:0] pending_tracks [MAX_REQUESTS];
  int                 pending_len;

  // Head position and movement while a batch is being planned.
  int head_now;
  int moved_now;

  visit_t visit_q[$];

  initial begin
    mismatches     = 0;
    visits_due     = 0;
    visits_checked = 0;
  end

  // Moves the planned head to one track and queues that visit.
  task automatic log_visit(input int trk);
    int gap;
    visit_t v;
    gap       = (trk > head_now) ? trk - head_now : head_now - trk;
    moved_now = (moved_now + gap > int'(MOVE_MAX)) ? int'(MOVE_MAX) : moved_now + gap;
    head_now  = trk;
    v.trk     = trk[TRACK_W-1:0];
    v.moved   = '0;
    v.fin     = 1'b0;
    visit_q.push_back(v);
  endtask

  // Sorts the batch and queues the whole elevator sweep for it.
  task automatic plan_sweep();
    logic [TRACK_W-1:0] sorted [MAX_REQUESTS];
    logic [TRACK_W-1:0] v;
    visit_t             tail;
    int                 i;
    int                 j;
    int                 split;
    int                 top;
    for (i = 0; i < pending_len; i++) sorted[i] = pending_tracks[i];
    for (i = 1; i < pending_len; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end

    // The split is the first request strictly above the head.
    split = pending_len;
    for (i = pending_len - 1; i >= 0; i--) begin
      if (sorted[i] > head_q) split = i;
    end

    if (size_q == '0) begin
      top = 0;
    end else if (size_q > DISK_SIZE_MAX) begin
      top = (1 << TRACK_W) - 1;
    end else begin
      top = size_q - 1;
    end

    head_now  = head_q;
    moved_now = 0;
    if (dir_q) begin
      for (i = split; i < pending_len; i++) log_visit(sorted[i]);
      log_visit(top);
      for (i = split; i > 0; i--) log_visit(sorted[i-1]);
    end else begin
      for (i = split; i > 0; i--) log_visit(sorted[i-1]);
      log_visit(0);
      for (i = split; i < pending_len; i++) log_visit(sorted[i]);
    end

    // The closing visit carries the movement total.
    tail       = visit_q.pop_back();
    tail.moved = moved_now[MOVE_W-1:0];
    tail.fin   = 1'b1;
    visit_q.push_back(tail);
    pending_len = 0;
  endtask

  always @(posedge clk) begin
    visit_t want;
    if (rst) begin
      size_q      = DISK_SIZE_RST;
      head_q      = HEAD_START_RST;
      dir_q       = DIRECTION_RST;
      pending_len = 0;
      visit_q.delete();
    end else begin
      // Track register writes.
      if (cfg_we) begin
        case (cfg_idx)
          REG_DISK_SIZE:  size_q = cfg_wdata;
          REG_HEAD_START: head_q = cfg_wdata[TRACK_W-1:0];
          REG_DIRECTION:  dir_q  = cfg_wdata[0];
          default: ;
        endcase
      end

      // Compare each accepted result item with the oldest prediction.
      if (res.valid && res.ready) begin
        if (visit_q.size() == 0) begin
          mismatches++;
          $display("%0t: result item with nothing expected: track %0d movement %0d final %0b",
                   $time, res.serviced_track, res.total_movement, res.final_res);
        end else begin
          want = visit_q.pop_front();
          visits_checked++;
          if (res.serviced_track !== want.trk) begin
            mismatches++;
            $display("%0t: serviced_track expected %0d got %0d",
                     $time, want.trk, res.serviced_track);
          end
          if (res.total_movement !== want.moved) begin
            mismatches++;
            $display("%0t: total_movement expected %0d got %0d",
                     $time, want.moved, res.total_movement);
          end
          if (res.final_res !== want.fin) begin
            mismatches++;
            $display("%0t: final_res expected %0b got %0b", $time, want.fin, res.final_res);
          end
        end
      end

      // Store accepted requests; a full store drops them, but last still counts.
      if (req.valid && req.ready) begin
        if (pending_len < MAX_REQUESTS) begin
          pending_tracks[pending_len] = req.track;
          pending_len++;
        end
        if (req.last) plan_sweep();
      end
    end
    visits_due = visit_q.size();
  end

endmodule

// ===== dv/tb_scan_disk_scheduler_core.sv =====
`timescale 1ns / 100ps

module tb_scan_disk_scheduler_core;
  import sds_pkg::*;

  localparam int REQUEST_TARGET = 90;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 10;
  localparam int DRAIN_LIMIT    = 50000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sds_req_if req ();
  sds_res_if res ();

  int mismatches;
  int visits_due;
  int visits_checked;

  // Stimulus bookkeeping and shared controls for both sides.
  int                 requests_sent;
  int                 batches_sent;
  int                 settings_used;
  bit                 quiet_span;
  bit                 stall_results;
  logic [TRACK_W-1:0] cur_head;
  logic [SIZE_W-1:0]  cur_size;

  scan_disk_scheduler_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .res       (res)
  );

  scan_order_checker order_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .req            (req),
    .res            (res),
    .mismatches     (mismatches),
    .visits_due     (visits_due),
    .visits_checked (visits_checked)
  );

  always #6 clk = ~clk;

  // Offers one request item, sometimes after a one-cycle gap, and waits until taken.
  task automatic offer_request(input logic [TRACK_W-1:0] trk, input logic last);
    if (!quiet_span && $urandom_range(99) < 11) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.track <= trk;
    req.last  <= last;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    requests_sent++;
    if (last) batches_sent++;
  endtask

  // Stops offering and waits until every predicted visit has come out or the drain limit is reached.
  task automatic wait_idle();
    int guard;
    guard = 0;
    req.valid <= 1'b0;
    @(posedge clk);
    while (visits_due != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers, one per cycle.
  task automatic set_config(input logic [SIZE_W-1:0] size, input logic [TRACK_W-1:0] head,
                            input logic dir);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_DISK_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_idx   <= REG_HEAD_START;
    cfg_wdata <= {1'b0, head};
    @(posedge clk);
    cfg_idx   <= REG_DIRECTION;
    cfg_wdata <= CFG_DATA_W'(dir);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_size   = size;
    cur_head   = head;
    settings_used++;
  endtask

  // Picks a setting, with the extremes of every register among the choices.
  task automatic random_config();
    case ($urandom_range(5))
      0: set_config(SIZE_W'($urandom_range(0, 1)), TRACK_W'($urandom_range(0, 4095)),
                    1'($urandom_range(1)));
      1: set_config(DISK_SIZE_MAX, 12'hFFF, 1'($urandom_range(1)));
      2: set_config(13'h1FFF, 12'h000, 1'($urandom_range(1)));
      default: set_config(SIZE_W'($urandom_range(1, 4096)), TRACK_W'($urandom_range(0, 4095)),
                          1'($urandom_range(1)));
    endcase
  endtask

  // Tracks cluster around the head, hit the extremes, or spread over the disk.
  function automatic logic [TRACK_W-1:0] pick_track();
    int t;
    case ($urandom_range(3))
      0: begin
        t = int'(cur_head) + $urandom_range(0, 128) - 64;
        if (t < 0) t = 0;
        if (t > 4095) t = 4095;
      end
      1: begin
        case ($urandom_range(2))
          0: t = 0;
          1: t = 4095;
          default: t = (cur_size == '0) ? 0 : ((cur_size > DISK_SIZE_MAX) ? 4095 : cur_size - 1);
        endcase
      end
      default: t = $urandom_range(0, 4095);
    endcase
    return t[TRACK_W-1:0];
  endfunction

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_results) begin
        stall_results = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res.ready <= !rst && (quiet_span || $urandom_range(99) >= 11);
    end
  end

  // Run limit.
  initial begin
    #4800000;
    $display("tb_scan_disk_scheduler_core: done, errors");
    $finish;
  end

  initial begin
    int random_requests;
    int batch_no;
    int len;
    int k;
    req.valid     = 1'b0;
    req.track     = '0;
    req.last      = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_DISK_SIZE;
    cfg_wdata     = '0;
    requests_sent = 0;
    batches_sent  = 0;
    settings_used = 0;
    quiet_span    = 1'b0;
    stall_results = 1'b0;
    cur_head      = HEAD_START_RST;
    cur_size      = DISK_SIZE_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: track extremes, one request beyond the top track.
    offer_request(12'd50, 1'b0);
    offer_request(12'd199, 1'b0);
    offer_request(12'd0, 1'b0);
    offer_request(12'hFFF, 1'b1);
    wait_idle();

    // Moving down from the top with nothing above the head, two at the head.
    set_config(DISK_SIZE_MAX, 12'hFFF, 1'b0);
    offer_request(12'hFFF, 1'b0);
    offer_request(12'd0, 1'b0);
    offer_request(12'd2048, 1'b0);
    offer_request(12'hFFF, 1'b1);
    wait_idle();

    // Zero disk size puts the top track at zero.
    set_config(13'd0, 12'd100, 1'b1);
    offer_request(12'd100, 1'b0);
    offer_request(12'd101, 1'b0);
    offer_request(12'd3, 1'b1);
    wait_idle();

    // Oversized disk with a single request, sweeping down.
    set_config(13'h1FFF, 12'd2000, 1'b0);
    offer_request(12'd1, 1'b1);
    wait_idle();

    // One-track disk: a single-request batch, then two more batches, all without a pause.
    set_config(13'd1, 12'd0, 1'b1);
    offer_request(12'd0, 1'b1);
    offer_request(12'd7, 1'b0);
    offer_request(12'd7, 1'b0);
    offer_request(12'd3000, 1'b1);
    offer_request(12'd12, 1'b1);
    wait_idle();

    // Random batches: mostly short, now and then past the store depth.
    random_requests = 0;
    batch_no        = 0;
    while (random_requests < REQUEST_TARGET) begin
      if (batch_no == 0 || (batch_no != 3 && $urandom_range(2) == 0)) begin
        wait_idle();
        random_config();
      end
      quiet_span = (random_requests >= 40 && random_requests < 75);
      if (batch_no == 4) begin
        len = MAX_REQUESTS + 3;
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
      end
      for (k = 0; k < len; k++) begin
        offer_request(pick_track(), k == len - 1);
        random_requests++;
      end
      // Hold the results back while the next batch is already being offered.
      if (batch_no == 2) stall_results = 1'b1;
      batch_no++;
    end
    quiet_span = 1'b0;
    wait_idle();

    $display("Sent %0d requests in %0d batches under %0d register settings.",
             requests_sent, batches_sent, settings_used + 1);
    $display("Checked %0d visits, including a full store and a %0d-cycle result hold-off.",
             visits_checked, HOLD_CYCLES);
    if (visits_due != 0) begin
      $display("%0t: %0d expected visits never came out", $time, visits_due);
    end
    if (mismatches == 0 && visits_due == 0) begin
      $display("tb_scan_disk_scheduler_core: done, clean");
    end else begin
      $display("tb_scan_disk_scheduler_core: done, errors");
    end
    $finish;
  end

endmodule
